// ----- rtl/chord_mapping_table_engine_defines.svh -----
// assertion helpers shared by the chord mapping table engine
`ifndef CHORD_MAPPING_TABLE_ENGINE_DEFINES_SVH
`define CHORD_MAPPING_TABLE_ENGINE_DEFINES_SVH

// same-cycle implication, off during reset
`define CMTE_ASSERT_IMP(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// next-cycle implication, off during reset
`define CMTE_ASSERT_NXT(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

// ----- rtl/cmte_pkg.sv -----
`timescale 1ns / 1ps

package cmte_pkg;

   // default table depths
   localparam int KEY_ENTRIES_DEF   = 256;
   localparam int MOUSE_ENTRIES_DEF = 32;
   localparam int MEDIA_ENTRIES_DEF = 32;

   // field widths
   localparam int CHORD_W      = 16;
   localparam int KEY_MOD_W    = 4;
   localparam int KEY_CODE_W   = 8;
   localparam int KEY_DATA_W   = KEY_MOD_W + KEY_CODE_W;
   localparam int MOUSE_DATA_W = 3;
   localparam int MEDIA_DATA_W = 16;
   localparam int KEY_CNT_W    = 9;
   localparam int MOUSE_CNT_W  = 6;
   localparam int MEDIA_CNT_W  = 6;
   localparam int SKIP_W       = 16;

   typedef enum logic [1:0] {
      OP_CLEAR  = 2'd0,
      OP_LOAD   = 2'd1,
      OP_LOOKUP = 2'd2,
      OP_NONE   = 2'd3
   } op_type;

   // record kinds
   localparam logic [7:0] EV_MOUSE    = 8'h01;
   localparam logic [7:0] EV_KEYBOARD = 8'h02;
   localparam logic [7:0] EV_MEDIA    = 8'h03;
   localparam logic [7:0] EV_SYSTEM   = 8'h07;
   localparam logic [7:0] EV_MACRO    = 8'hFF;

   // mouse function codes
   localparam logic [7:0] MFN_LEFT   = 8'h02;
   localparam logic [7:0] MFN_RIGHT  = 8'h0C;
   localparam logic [7:0] MFN_MIDDLE = 8'h0A;

   // config flag bit positions
   localparam int FLAG_SHIFT = 0;
   localparam int FLAG_CTRL  = 1;
   localparam int FLAG_ALT   = 2;
   localparam int FLAG_GUI   = 5;

   // commands from the sequencer to one table
   typedef struct packed {
      logic clear;
      logic append;
      logic scan;
   } tbl_cmd_type;

   // status from one table
   typedef struct packed {
      logic busy;
      logic full;
      logic hit;
   } tbl_stat_type;

   // result register contents
   typedef struct packed {
      logic                    key_hit;
      logic [KEY_MOD_W-1:0]    key_modifiers;
      logic [KEY_CODE_W-1:0]   key_code;
      logic                    mouse_hit;
      logic [MOUSE_DATA_W-1:0] mouse_buttons;
      logic                    media_hit;
      logic [MEDIA_DATA_W-1:0] consumer_usage;
      logic                    record_stored;
      logic [KEY_CNT_W-1:0]    key_entries_now;
      logic [MOUSE_CNT_W-1:0]  mouse_entries_now;
      logic [MEDIA_CNT_W-1:0]  media_entries_now;
      logic [SKIP_W-1:0]       skipped_total;
   } rsp_type;

   // config flags to hid modifier bits (ctrl, shift, alt, gui from bit 0 up)
   function automatic logic [KEY_MOD_W-1:0] flags_to_hid(input logic [7:0] f);
      return {f[FLAG_GUI], f[FLAG_ALT], f[FLAG_SHIFT], f[FLAG_CTRL]};
   endfunction

   // mouse function code to button bits
   function automatic logic [MOUSE_DATA_W-1:0] func_to_buttons(input logic [7:0] f);
      logic [MOUSE_DATA_W-1:0] b;
      unique case (f)
         MFN_LEFT:   b = 3'b001;
         MFN_RIGHT:  b = 3'b010;
         MFN_MIDDLE: b = 3'b100;
         default:    b = 3'b000;
      endcase
      return b;
   endfunction

endpackage

// ----- rtl/cmte_if.sv -----
`timescale 1ns / 1ps

// request channel
interface cmte_req_if;
   logic        valid;
   logic        ready;
   logic [1:0]  op;
   logic [15:0] chord;
   logic [7:0]  rec_kind;
   logic [7:0]  event_flags;
   logic [15:0] code;

   modport source (output valid, op, chord, rec_kind, event_flags, code, input ready);
   modport sink   (input valid, op, chord, rec_kind, event_flags, code, output ready);
endinterface

// response channel
interface cmte_rsp_if;
   logic        valid;
   logic        ready;
   logic        key_hit;
   logic [3:0]  key_modifiers;
   logic [7:0]  key_code;
   logic        mouse_hit;
   logic [2:0]  mouse_buttons;
   logic        media_hit;
   logic [15:0] consumer_usage;
   logic        record_stored;
   logic [8:0]  key_entries_now;
   logic [5:0]  mouse_entries_now;
   logic [5:0]  media_entries_now;
   logic [15:0] skipped_total;

   modport source (output valid, key_hit, key_modifiers, key_code, mouse_hit, mouse_buttons,
                   media_hit, consumer_usage, record_stored, key_entries_now,
                   mouse_entries_now, media_entries_now, skipped_total, input ready);
   modport sink   (input valid, key_hit, key_modifiers, key_code, mouse_hit, mouse_buttons,
                   media_hit, consumer_usage, record_stored, key_entries_now,
                   mouse_entries_now, media_entries_now, skipped_total, output ready);
endinterface

// ----- rtl/chord_mapping_table_engine.sv -----
`timescale 1ns / 1ps
`include "chord_mapping_table_engine_defines.svh"

// Chord mapping table engine: keyboard, mouse and media tables, each in its own
// single-port synchronous memory with a fill count. A clear, a record load or the
// unused op moves from idle to the write state, which registers the response and
// frees the input as that response appears. A lookup scans the three tables side
// by side, one entry per table per cycle through each memory's read port, and goes
// to the write state once every table has matched or read all its filled entries,
// so it takes longest with a full keyboard table (an early match in every table
// ends it sooner). One request is in work at a time; a new request is taken while
// the previous response still waits in the output register, and a response still
// held when the next one is to be written stalls the input. Reset and clear only
// zero the fill counts and skip counters, so no clearing pass is needed.
module chord_mapping_table_engine #(
   parameter int KEY_ENTRIES   = cmte_pkg::KEY_ENTRIES_DEF,
   parameter int MOUSE_ENTRIES = cmte_pkg::MOUSE_ENTRIES_DEF,
   parameter int MEDIA_ENTRIES = cmte_pkg::MEDIA_ENTRIES_DEF
) (
   input  logic       clock,
   input  logic       reset,
   cmte_req_if.sink   req_ch,
   cmte_rsp_if.source rsp_ch
);

   localparam int KCW = $clog2(KEY_ENTRIES + 1);
   localparam int MCW = $clog2(MOUSE_ENTRIES + 1);
   localparam int DCW = $clog2(MEDIA_ENTRIES + 1);

   typedef enum logic [2:0] {
      ST_IDLE  = 3'b001,
      ST_SCAN  = 3'b010,
      ST_WRITE = 3'b100
   } state_type;

   state_type                      state_ff, state_in;
   cmte_pkg::rsp_type              rsp_ff, rsp_in;
   logic                           rsp_valid_ff, rsp_valid_in;
   logic                           lookup_ff, stored_ff, stored_in;
   logic [cmte_pkg::SKIP_W-1:0]    sys_skip_ff, sys_skip_in, unk_skip_ff, unk_skip_in;
   logic                           accept, out_free, tables_idle;
   cmte_pkg::op_type               op;
   logic                           is_load, is_key, is_mouse, is_media, is_sys, is_unk;
   cmte_pkg::tbl_cmd_type          key_cmd, mouse_cmd, media_cmd;
   cmte_pkg::tbl_stat_type         key_stat, mouse_stat, media_stat;
   logic [cmte_pkg::KEY_DATA_W-1:0]   key_wdata, key_hdata;
   logic [cmte_pkg::MOUSE_DATA_W-1:0] mouse_wdata, mouse_hdata;
   logic [cmte_pkg::MEDIA_DATA_W-1:0] media_wdata, media_hdata;
   logic [KCW-1:0]                 key_used;
   logic [MCW-1:0]                 mouse_used;
   logic [DCW-1:0]                 media_used;

   assign req_ch.ready = (state_ff == ST_IDLE);
   assign accept       = req_ch.valid && req_ch.ready;
   assign op           = cmte_pkg::op_type'(req_ch.op);
   assign out_free     = !rsp_valid_ff || rsp_ch.ready;
   assign tables_idle  = !key_stat.busy && !mouse_stat.busy && !media_stat.busy;

   // record kind decode
   always_comb begin
      is_key   = 1'b0;
      is_mouse = 1'b0;
      is_media = 1'b0;
      is_sys   = 1'b0;
      is_unk   = 1'b0;
      unique case (req_ch.rec_kind)
         cmte_pkg::EV_KEYBOARD: is_key   = 1'b1;
         cmte_pkg::EV_MOUSE:    is_mouse = 1'b1;
         cmte_pkg::EV_MEDIA:    is_media = 1'b1;
         cmte_pkg::EV_SYSTEM:   is_sys   = 1'b1;
         cmte_pkg::EV_MACRO:    is_unk   = 1'b0;
         default:               is_unk   = 1'b1;
      endcase
   end

   assign is_load = accept && (op == cmte_pkg::OP_LOAD);

   // table commands
   always_comb begin
      key_cmd.clear    = accept && (op == cmte_pkg::OP_CLEAR);
      key_cmd.scan     = accept && (op == cmte_pkg::OP_LOOKUP);
      key_cmd.append   = is_load && is_key;
      mouse_cmd        = key_cmd;
      mouse_cmd.append = is_load && is_mouse;
      media_cmd        = key_cmd;
      media_cmd.append = is_load && is_media;
   end

   assign key_wdata   = {cmte_pkg::flags_to_hid(req_ch.event_flags), req_ch.code[7:0]};
   assign mouse_wdata = cmte_pkg::func_to_buttons(req_ch.event_flags);
   assign media_wdata = req_ch.code;

   cmte_table #(.DEPTH(KEY_ENTRIES), .DATA_W(cmte_pkg::KEY_DATA_W)) u_key (
      .clock, .reset, .cmd(key_cmd), .key(req_ch.chord), .wdata(key_wdata),
      .stat(key_stat), .hit_data(key_hdata), .used(key_used)
   );

   cmte_table #(.DEPTH(MOUSE_ENTRIES), .DATA_W(cmte_pkg::MOUSE_DATA_W)) u_mouse (
      .clock, .reset, .cmd(mouse_cmd), .key(req_ch.chord), .wdata(mouse_wdata),
      .stat(mouse_stat), .hit_data(mouse_hdata), .used(mouse_used)
   );

   cmte_table #(.DEPTH(MEDIA_ENTRIES), .DATA_W(cmte_pkg::MEDIA_DATA_W)) u_media (
      .clock, .reset, .cmd(media_cmd), .key(req_ch.chord), .wdata(media_wdata),
      .stat(media_stat), .hit_data(media_hdata), .used(media_used)
   );

   // store flag and skip counters
   always_comb begin
      stored_in   = stored_ff;
      sys_skip_in = sys_skip_ff;
      unk_skip_in = unk_skip_ff;
      if (accept) begin
         stored_in = is_load && ((is_key && !key_stat.full) || (is_mouse && !mouse_stat.full)
                                 || (is_media && !media_stat.full));
      end
      if (key_cmd.clear) begin
         sys_skip_in = '0;
         unk_skip_in = '0;
      end else if (is_load && is_sys) begin
         sys_skip_in = sys_skip_ff + cmte_pkg::SKIP_W'(1);
      end else if (is_load && is_unk) begin
         unk_skip_in = unk_skip_ff + cmte_pkg::SKIP_W'(1);
      end
   end

   // sequencer and response register
   always_comb begin
      state_in     = state_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ch.ready;
      rsp_in       = rsp_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               state_in = key_cmd.scan ? ST_SCAN : ST_WRITE;
            end
         end
         ST_SCAN: begin
            if (tables_idle) begin
               state_in = ST_WRITE;
            end
         end
         ST_WRITE: begin
            if (out_free) begin
               state_in                 = ST_IDLE;
               rsp_valid_in             = 1'b1;
               rsp_in.key_hit           = lookup_ff && key_stat.hit;
               rsp_in.key_modifiers     = (lookup_ff && key_stat.hit) ?
                                          key_hdata[cmte_pkg::KEY_DATA_W-1 -: 4] : '0;
               rsp_in.key_code          = (lookup_ff && key_stat.hit) ? key_hdata[7:0] : '0;
               rsp_in.mouse_hit         = lookup_ff && mouse_stat.hit;
               rsp_in.mouse_buttons     = (lookup_ff && mouse_stat.hit) ? mouse_hdata : '0;
               rsp_in.media_hit         = lookup_ff && media_stat.hit;
               rsp_in.consumer_usage    = (lookup_ff && media_stat.hit) ? media_hdata : '0;
               rsp_in.record_stored     = stored_ff;
               rsp_in.key_entries_now   = cmte_pkg::KEY_CNT_W'(key_used);
               rsp_in.mouse_entries_now = cmte_pkg::MOUSE_CNT_W'(mouse_used);
               rsp_in.media_entries_now = cmte_pkg::MEDIA_CNT_W'(media_used);
               rsp_in.skipped_total     = sys_skip_ff + unk_skip_ff;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
         sys_skip_ff  <= '0;
         unk_skip_ff  <= '0;
         stored_ff    <= 1'b0;
         lookup_ff    <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         sys_skip_ff  <= sys_skip_in;
         unk_skip_ff  <= unk_skip_in;
         stored_ff    <= stored_in;
         if (accept) begin
            lookup_ff <= key_cmd.scan;
         end
      end
   end

   always_ff @(posedge clock) begin
      rsp_ff <= rsp_in;
   end

   // response ports
   assign rsp_ch.valid             = rsp_valid_ff;
   assign rsp_ch.key_hit           = rsp_ff.key_hit;
   assign rsp_ch.key_modifiers     = rsp_ff.key_modifiers;
   assign rsp_ch.key_code          = rsp_ff.key_code;
   assign rsp_ch.mouse_hit         = rsp_ff.mouse_hit;
   assign rsp_ch.mouse_buttons     = rsp_ff.mouse_buttons;
   assign rsp_ch.media_hit         = rsp_ff.media_hit;
   assign rsp_ch.consumer_usage    = rsp_ff.consumer_usage;
   assign rsp_ch.record_stored     = rsp_ff.record_stored;
   assign rsp_ch.key_entries_now   = rsp_ff.key_entries_now;
   assign rsp_ch.mouse_entries_now = rsp_ff.mouse_entries_now;
   assign rsp_ch.media_entries_now = rsp_ff.media_entries_now;
   assign rsp_ch.skipped_total     = rsp_ff.skipped_total;

   `CMTE_ASSERT_NXT(a_lookup_scan, clock, reset, key_cmd.scan, state_ff == ST_SCAN, "no scan")
   `CMTE_ASSERT_IMP(a_write_quiet, clock, reset, state_ff == ST_WRITE, tables_idle, "busy at write")
   `CMTE_ASSERT_NXT(a_clear_skips, clock, reset, key_cmd.clear, sys_skip_ff == '0, "skips kept")

endmodule

// ----- rtl/cmte_table.sv -----
`timescale 1ns / 1ps
`include "chord_mapping_table_engine_defines.svh"

module cmte_table #(
   parameter int DEPTH  = cmte_pkg::KEY_ENTRIES_DEF,
   parameter int DATA_W = cmte_pkg::KEY_DATA_W,
   localparam int CW    = $clog2(DEPTH + 1)
) (
   input  logic                          clock,
   input  logic                          reset,
   input  cmte_pkg::tbl_cmd_type         cmd,
   input  logic [cmte_pkg::CHORD_W-1:0]  key,
   input  logic [DATA_W-1:0]             wdata,
   output cmte_pkg::tbl_stat_type        stat,
   output logic [DATA_W-1:0]             hit_data,
   output logic [CW-1:0]                 used
);

   localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int EW = cmte_pkg::CHORD_W + DATA_W;

   logic [EW-1:0]                mem_ff [DEPTH];
   logic [EW-1:0]                rd_ff;
   logic [CW-1:0]                used_ff, used_in;
   logic [CW-1:0]                addr_ff, addr_in;
   logic                         pend_ff, pend_in;
   logic                         scan_ff, scan_in;
   logic                         hit_ff, hit_in;
   logic [cmte_pkg::CHORD_W-1:0] key_ff;
   logic [DATA_W-1:0]            hdata_ff;
   logic                         full, wr_en, issue, match;

   assign full  = (used_ff == CW'(DEPTH));
   assign wr_en = cmd.append && !full;
   assign match = pend_ff && (rd_ff[EW-1 -: cmte_pkg::CHORD_W] == key_ff);
   assign issue = scan_ff && !match && (addr_ff < used_ff);

   // entry store, appended at the fill count, read one entry a cycle during a scan
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[used_ff[AW-1:0]] <= {key, wdata};
      end
      if (issue) begin
         rd_ff <= mem_ff[addr_ff[AW-1:0]];
      end
   end

   // fill count and scan sequencing
   always_comb begin
      used_in = used_ff;
      addr_in = addr_ff;
      pend_in = pend_ff;
      scan_in = scan_ff;
      hit_in  = hit_ff;
      if (cmd.clear) begin
         used_in = '0;
      end else if (wr_en) begin
         used_in = used_ff + CW'(1);
      end
      if (cmd.scan) begin
         scan_in = 1'b1;
         addr_in = '0;
         pend_in = 1'b0;
         hit_in  = 1'b0;
      end else if (scan_ff) begin
         pend_in = issue;
         if (issue) begin
            addr_in = addr_ff + CW'(1);
         end
         if (match) begin
            scan_in = 1'b0;
            hit_in  = 1'b1;
         end else if (!issue) begin
            scan_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         used_ff <= '0;
         addr_ff <= '0;
         pend_ff <= 1'b0;
         scan_ff <= 1'b0;
         hit_ff  <= 1'b0;
      end else begin
         used_ff <= used_in;
         addr_ff <= addr_in;
         pend_ff <= pend_in;
         scan_ff <= scan_in;
         hit_ff  <= hit_in;
      end
   end

   // search key and first-match data
   always_ff @(posedge clock) begin
      if (cmd.scan) begin
         key_ff <= key;
      end
      if (match && scan_ff) begin
         hdata_ff <= rd_ff[DATA_W-1:0];
      end
   end

   assign stat.busy = scan_ff;
   assign stat.full = full;
   assign stat.hit  = hit_ff;
   assign hit_data  = hdata_ff;
   assign used      = used_ff;

   `CMTE_ASSERT_IMP(a_used_bound, clock, reset, 1'b1, used_ff <= CW'(DEPTH), "fill count past depth")
   `CMTE_ASSERT_IMP(a_scan_addr, clock, reset, scan_ff, addr_ff <= used_ff, "scan ran past fill")
   `CMTE_ASSERT_NXT(a_clear_used, clock, reset, cmd.clear, used_ff == '0, "clear left entries")
   `CMTE_ASSERT_IMP(a_no_wr_scan, clock, reset, wr_en, !scan_ff, "append during scan")

endmodule

// ----- sim/tb_chord_mapping_table_engine.sv -----
`timescale 1ns / 1ps

module tb_chord_mapping_table_engine;

   // one request as the sender drives it
   typedef struct packed {
      cmte_pkg::op_type op;
      logic [15:0]      chord;
      logic [7:0]       rec_kind;
      logic [7:0]       event_flags;
      logic [15:0]      code;
   } chord_request_type;

   // directed row: request plus a hand-written response where it is obvious
   typedef struct {
      chord_request_type req;
      bit                pinned;
      cmte_pkg::rsp_type want;
   } probe_row_type;

   typedef struct packed {
      logic [15:0] chord;
      logic [3:0]  mods;
      logic [7:0]  code;
   } key_slot_type;

   typedef struct packed {
      logic [15:0] chord;
      logic [2:0]  buttons;
   } mouse_slot_type;

   typedef struct packed {
      logic [15:0] chord;
      logic [15:0] usage;
   } media_slot_type;

   localparam int RANDOM_ITEMS = 850;
   localparam int SKIP_RECORDS = 40;
   localparam int HOLD_CYCLES  = 500;
   localparam int DRAIN_CYCLES = 300;
   localparam int MAX_REPORTS  = 100;

   logic clock;
   logic reset;

   cmte_req_if req_ch ();
   cmte_rsp_if rsp_ch ();

   chord_mapping_table_engine dut (
      .clock (clock),
      .reset (reset),
      .req_ch(req_ch),
      .rsp_ch(rsp_ch)
   );

   // mirror of the tables
   key_slot_type   key_map   [cmte_pkg::KEY_ENTRIES_DEF];
   mouse_slot_type mouse_map [cmte_pkg::MOUSE_ENTRIES_DEF];
   media_slot_type media_map [cmte_pkg::MEDIA_ENTRIES_DEF];
   int             key_fill;
   int             mouse_fill;
   int             media_fill;
   logic [15:0]    system_skip_count;
   logic [15:0]    unknown_skip_count;

   cmte_pkg::rsp_type pending_responses [$];
   int                mismatches;
   int                requests_taken;
   int                offered;

   // sender state
   bit                cur_pinned;
   cmte_pkg::rsp_type cur_want;
   bit                steady;
   int                burst_left;
   logic [15:0]       chord_pool [8];

   probe_row_type     probe_table [25];

   // clock
   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // expected response for one accepted request, updating the mirror
   function automatic cmte_pkg::rsp_type apply_request(input chord_request_type r);
      cmte_pkg::rsp_type o;
      logic [3:0]        mods;
      logic [2:0]        btn;
      int                i;
      o = '0;
      case (r.op)
         cmte_pkg::OP_CLEAR: begin
            key_fill           = 0;
            mouse_fill         = 0;
            media_fill         = 0;
            system_skip_count  = '0;
            unknown_skip_count = '0;
         end
         cmte_pkg::OP_LOAD: begin
            if (r.rec_kind == cmte_pkg::EV_KEYBOARD) begin
               if (key_fill < cmte_pkg::KEY_ENTRIES_DEF) begin
                  mods = '0;
                  if (r.event_flags[cmte_pkg::FLAG_CTRL])  mods[0] = 1'b1;
                  if (r.event_flags[cmte_pkg::FLAG_SHIFT]) mods[1] = 1'b1;
                  if (r.event_flags[cmte_pkg::FLAG_ALT])   mods[2] = 1'b1;
                  if (r.event_flags[cmte_pkg::FLAG_GUI])   mods[3] = 1'b1;
                  key_map[key_fill] = '{chord: r.chord, mods: mods, code: r.code[7:0]};
                  key_fill++;
                  o.record_stored = 1'b1;
               end
            end else if (r.rec_kind == cmte_pkg::EV_MOUSE) begin
               if (mouse_fill < cmte_pkg::MOUSE_ENTRIES_DEF) begin
                  if (r.event_flags == cmte_pkg::MFN_LEFT)        btn = 3'd1;
                  else if (r.event_flags == cmte_pkg::MFN_RIGHT)  btn = 3'd2;
                  else if (r.event_flags == cmte_pkg::MFN_MIDDLE) btn = 3'd4;
                  else                                            btn = 3'd0;
                  mouse_map[mouse_fill] = '{chord: r.chord, buttons: btn};
                  mouse_fill++;
                  o.record_stored = 1'b1;
               end
            end else if (r.rec_kind == cmte_pkg::EV_MEDIA) begin
               if (media_fill < cmte_pkg::MEDIA_ENTRIES_DEF) begin
                  media_map[media_fill] = '{chord: r.chord, usage: r.code};
                  media_fill++;
                  o.record_stored = 1'b1;
               end
            end else if (r.rec_kind == cmte_pkg::EV_SYSTEM) begin
               system_skip_count = system_skip_count + 16'd1;
            end else if (r.rec_kind != cmte_pkg::EV_MACRO) begin
               unknown_skip_count = unknown_skip_count + 16'd1;
            end
         end
         cmte_pkg::OP_LOOKUP: begin
            // oldest match wins in each table
            for (i = 0; i < key_fill && !o.key_hit; i++) begin
               if (key_map[i].chord == r.chord) begin
                  o.key_hit       = 1'b1;
                  o.key_modifiers = key_map[i].mods;
                  o.key_code      = key_map[i].code;
               end
            end
            for (i = 0; i < mouse_fill && !o.mouse_hit; i++) begin
               if (mouse_map[i].chord == r.chord) begin
                  o.mouse_hit     = 1'b1;
                  o.mouse_buttons = mouse_map[i].buttons;
               end
            end
            for (i = 0; i < media_fill && !o.media_hit; i++) begin
               if (media_map[i].chord == r.chord) begin
                  o.media_hit      = 1'b1;
                  o.consumer_usage = media_map[i].usage;
               end
            end
         end
         default: begin
         end
      endcase
      o.key_entries_now   = key_fill[cmte_pkg::KEY_CNT_W-1:0];
      o.mouse_entries_now = mouse_fill[cmte_pkg::MOUSE_CNT_W-1:0];
      o.media_entries_now = media_fill[cmte_pkg::MEDIA_CNT_W-1:0];
      o.skipped_total     = system_skip_count + unknown_skip_count;
      return o;
   endfunction

   function automatic chord_request_type make_request(input cmte_pkg::op_type op,
                                                      input logic [15:0] chord,
                                                      input logic [7:0] ev,
                                                      input logic [7:0] flags,
                                                      input logic [15:0] code);
      chord_request_type r;
      r.op          = op;
      r.chord       = chord;
      r.rec_kind    = ev;
      r.event_flags = flags;
      r.code        = code;
      return r;
   endfunction

   // response that carries only the store flag and the fill counts
   function automatic cmte_pkg::rsp_type pinned_rsp(input bit stored, input int k,
                                                    input int m, input int d);
      cmte_pkg::rsp_type p;
      p                   = '0;
      p.record_stored     = stored;
      p.key_entries_now   = k[cmte_pkg::KEY_CNT_W-1:0];
      p.mouse_entries_now = m[cmte_pkg::MOUSE_CNT_W-1:0];
      p.media_entries_now = d[cmte_pkg::MEDIA_CNT_W-1:0];
      return p;
   endfunction

   // record kind that is none of the known ones
   function automatic logic [7:0] pick_unknown_type();
      logic [7:0] t;
      do begin
         t = 8'($urandom_range(0, 255));
      end while (t == cmte_pkg::EV_MOUSE || t == cmte_pkg::EV_KEYBOARD ||
                 t == cmte_pkg::EV_MEDIA || t == cmte_pkg::EV_SYSTEM ||
                 t == cmte_pkg::EV_MACRO);
      return t;
   endfunction

   // mostly chords already in the pool, so lookups hit
   function automatic logic [15:0] pick_chord();
      if ($urandom_range(0, 9) < 8) return chord_pool[$urandom_range(0, 7)];
      return 16'($urandom);
   endfunction

   function automatic chord_request_type random_record(input logic [7:0] ev,
                                                       input logic [15:0] chord);
      logic [7:0] flags;
      flags = 8'($urandom);
      if (ev == cmte_pkg::EV_MOUSE) begin
         case ($urandom_range(0, 3))
            0: flags = cmte_pkg::MFN_LEFT;
            1: flags = cmte_pkg::MFN_RIGHT;
            2: flags = cmte_pkg::MFN_MIDDLE;
            default: ;
         endcase
      end
      return make_request(cmte_pkg::OP_LOAD, chord, ev, flags, 16'($urandom));
   endfunction

   function automatic chord_request_type random_lookup();
      return make_request(cmte_pkg::OP_LOOKUP, pick_chord(), 8'($urandom), 8'($urandom),
                          16'($urandom));
   endfunction

   function automatic chord_request_type random_request();
      int         roll;
      int         kind;
      logic [7:0] ev;
      roll = $urandom_range(0, 99);
      if (roll < 45) begin
         kind = $urandom_range(0, 99);
         if (kind < 30)      ev = cmte_pkg::EV_KEYBOARD;
         else if (kind < 55) ev = cmte_pkg::EV_MOUSE;
         else if (kind < 80) ev = cmte_pkg::EV_MEDIA;
         else if (kind < 87) ev = cmte_pkg::EV_SYSTEM;
         else if (kind < 93) ev = cmte_pkg::EV_MACRO;
         else                ev = pick_unknown_type();
         return random_record(ev, pick_chord());
      end
      if (roll < 88) return random_lookup();
      if (roll < 95) begin
         return make_request(cmte_pkg::OP_NONE, 16'($urandom), 8'($urandom), 8'($urandom),
                             16'($urandom));
      end
      return make_request(cmte_pkg::OP_CLEAR, 16'($urandom), 8'($urandom), 8'($urandom),
                          16'($urandom));
   endfunction

   task automatic refresh_pool();
      int i;
      for (i = 0; i < 8; i++) chord_pool[i] = 16'($urandom);
      if ($urandom_range(0, 3) == 0) chord_pool[0] = 16'h0000;
      if ($urandom_range(0, 3) == 0) chord_pool[1] = 16'hFFFF;
   endtask

   task automatic check_field(input string tag, input int unsigned want,
                              input int unsigned got);
      if (want != got) begin
         mismatches++;
         if (mismatches <= MAX_REPORTS)
            $display("%0t ns: %s expected %0h actual %0h", $time, tag, want, got);
      end
   endtask

   task automatic compare_response(input cmte_pkg::rsp_type want,
                                   input cmte_pkg::rsp_type got);
      check_field("key_hit", want.key_hit, got.key_hit);
      check_field("key_modifiers", want.key_modifiers, got.key_modifiers);
      check_field("key_code", want.key_code, got.key_code);
      check_field("mouse_hit", want.mouse_hit, got.mouse_hit);
      check_field("mouse_buttons", want.mouse_buttons, got.mouse_buttons);
      check_field("media_hit", want.media_hit, got.media_hit);
      check_field("consumer_usage", want.consumer_usage, got.consumer_usage);
      check_field("record_stored", want.record_stored, got.record_stored);
      check_field("key_entries_now", want.key_entries_now, got.key_entries_now);
      check_field("mouse_entries_now", want.mouse_entries_now, got.mouse_entries_now);
      check_field("media_entries_now", want.media_entries_now, got.media_entries_now);
      check_field("skipped_total", want.skipped_total, got.skipped_total);
   endtask

   // drive one request at the falling edge and hold it until taken
   task automatic offer(input chord_request_type r, input bit pinned = 1'b0,
                        input cmte_pkg::rsp_type want = '0);
      @(negedge clock);
      req_ch.valid       = 1'b1;
      req_ch.op          = r.op;
      req_ch.chord       = r.chord;
      req_ch.rec_kind    = r.rec_kind;
      req_ch.event_flags = r.event_flags;
      req_ch.code        = r.code;
      cur_pinned         = pinned;
      cur_want           = want;
      @(posedge clock);
      while (!req_ch.ready) @(posedge clock);
      offered++;
      // bursts with random gaps
      if (!steady) begin
         if (burst_left > 0) begin
            burst_left--;
         end else begin
            @(negedge clock);
            req_ch.valid = 1'b0;
            repeat ($urandom_range(0, 10)) @(negedge clock);
            burst_left = $urandom_range(0, 20);
         end
      end
   endtask

   // fill every table past its depth, then look chords up against full tables
   task automatic fill_episode();
      int i;
      refresh_pool();
      offer(make_request(cmte_pkg::OP_CLEAR, 16'($urandom), 8'($urandom), 8'($urandom),
                         16'($urandom)));
      for (i = 0; i < cmte_pkg::KEY_ENTRIES_DEF + 4; i++) begin
         offer(random_record(cmte_pkg::EV_KEYBOARD,
                             ($urandom_range(0, 1) == 0) ? pick_chord() : 16'($urandom)));
         if (i % 32 == 0) offer(random_lookup());
      end
      for (i = 0; i < cmte_pkg::MOUSE_ENTRIES_DEF + 2; i++)
         offer(random_record(cmte_pkg::EV_MOUSE, pick_chord()));
      for (i = 0; i < cmte_pkg::MEDIA_ENTRIES_DEF + 2; i++)
         offer(random_record(cmte_pkg::EV_MEDIA, pick_chord()));
      repeat (30) offer(random_lookup());
   endtask

   // reset
   initial begin
      reset = 1'b1;
      repeat (2) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;
   end

   // receiver: random stalls, calm stretches, and one long hold-off
   initial begin
      int  calm;
      bit  hold_done;
      calm         = 0;
      hold_done    = 1'b0;
      rsp_ch.ready = 1'b0;
      forever begin
         @(negedge clock);
         if (!hold_done && requests_taken >= 30) begin
            hold_done    = 1'b1;
            rsp_ch.ready = 1'b0;
            repeat (HOLD_CYCLES - 1) @(negedge clock);
         end else if (calm > 0) begin
            calm--;
            rsp_ch.ready = 1'b1;
         end else if ($urandom_range(0, 31) == 0) begin
            calm         = $urandom_range(10, 80);
            rsp_ch.ready = 1'b1;
         end else begin
            rsp_ch.ready = ($urandom_range(0, 2) != 0);
         end
      end
   end

   // monitor: check responses, predict on accepted requests
   always @(posedge clock) begin
      cmte_pkg::rsp_type got;
      chord_request_type seen;
      if (!reset) begin
         if (rsp_ch.valid && rsp_ch.ready) begin
            got = {rsp_ch.key_hit, rsp_ch.key_modifiers, rsp_ch.key_code, rsp_ch.mouse_hit,
                   rsp_ch.mouse_buttons, rsp_ch.media_hit, rsp_ch.consumer_usage,
                   rsp_ch.record_stored, rsp_ch.key_entries_now, rsp_ch.mouse_entries_now,
                   rsp_ch.media_entries_now, rsp_ch.skipped_total};
            if (pending_responses.size() == 0) begin
               mismatches++;
               if (mismatches <= MAX_REPORTS)
                  $display("%0t ns: response with none expected, expected none actual %0h",
                           $time, got);
            end else begin
               compare_response(pending_responses.pop_front(), got);
            end
         end
         if (req_ch.valid && req_ch.ready) begin
            seen = make_request(cmte_pkg::op_type'(req_ch.op), req_ch.chord, req_ch.rec_kind,
                                req_ch.event_flags, req_ch.code);
            got  = apply_request(seen);
            pending_responses.push_back(cur_pinned ? cur_want : got);
            requests_taken++;
         end
      end
   end

   // stimulus
   initial begin
      int i;
      int random_start;
      req_ch.valid       = 1'b0;
      req_ch.op          = cmte_pkg::OP_NONE;
      req_ch.chord       = '0;
      req_ch.rec_kind    = '0;
      req_ch.event_flags = '0;
      req_ch.code        = '0;
      key_fill           = 0;
      mouse_fill         = 0;
      media_fill         = 0;
      system_skip_count  = '0;
      unknown_skip_count = '0;
      mismatches         = 0;
      requests_taken     = 0;
      offered            = 0;
      cur_pinned         = 1'b0;
      cur_want           = '0;
      steady             = 1'b0;
      burst_left         = 0;
      refresh_pool();

      // extremes, every record kind, duplicates, each op, clear
      probe_table = '{
         '{make_request(cmte_pkg::OP_LOOKUP, 16'h0000, 8'h00, 8'h00, 16'h0000), 1'b1, '0},
         '{make_request(cmte_pkg::OP_NONE, 16'hFFFF, 8'hFF, 8'hFF, 16'hFFFF), 1'b1, '0},
         '{make_request(cmte_pkg::OP_LOAD, 16'hFFFF, cmte_pkg::EV_KEYBOARD, 8'hFF, 16'hFFFF),
           1'b1, pinned_rsp(1'b1, 1, 0, 0)},
         '{make_request(cmte_pkg::OP_LOAD, 16'h0000, cmte_pkg::EV_KEYBOARD, 8'h00, 16'hFF00),
           1'b0, '0},
         '{make_request(cmte_pkg::OP_LOAD, 16'h0101, cmte_pkg::EV_KEYBOARD, 8'h21, 16'h0004),
           1'b0, '0},
         '{make_request(cmte_pkg::OP_LOAD, 16'hFFFF, cmte_pkg::EV_KEYBOARD, 8'h06, 16'h0011),
           1'b0, '0},
         '{make_request(cmte_pkg::OP_LOAD, 16'h1234, cmte_pkg::EV_MOUSE, cmte_pkg::MFN_LEFT,
                        16'h0000), 1'b0, '0},
         '{make_request(cmte_pkg::OP_LOAD, 16'h1234, cmte_pkg::EV_MOUSE, cmte_pkg::MFN_RIGHT,
                        16'h0000), 1'b0, '0},
         '{make_request(cmte_pkg::OP_LOAD, 16'h0101, cmte_pkg::EV_MOUSE, cmte_pkg::MFN_MIDDLE,
                        16'hFFFF), 1'b0, '0},
         '{make_request(cmte_pkg::OP_LOAD, 16'hFFFF, cmte_pkg::EV_MOUSE, 8'hFF, 16'h0000),
           1'b0, '0},
         '{make_request(cmte_pkg::OP_LOAD, 16'hFFFF, cmte_pkg::EV_MEDIA, 8'hFF, 16'hFFFF),
           1'b0, '0},
         '{make_request(cmte_pkg::OP_LOAD, 16'h0000, cmte_pkg::EV_MEDIA, 8'h00, 16'h0000),
           1'b0, '0},
         '{make_request(cmte_pkg::OP_LOAD, 16'h4321, cmte_pkg::EV_SYSTEM, 8'h00, 16'h0000),
           1'b0, '0},
         '{make_request(cmte_pkg::OP_LOAD, 16'h4321, cmte_pkg::EV_MACRO, 8'h00, 16'h0000),
           1'b0, '0},
         '{make_request(cmte_pkg::OP_LOAD, 16'h4321, 8'h00, 8'h00, 16'h0000), 1'b0, '0},
         '{make_request(cmte_pkg::OP_LOAD, 16'h4321, 8'hFE, 8'hFF, 16'hFFFF), 1'b0, '0},
         '{make_request(cmte_pkg::OP_LOOKUP, 16'hFFFF, 8'h00, 8'h00, 16'h0000), 1'b0, '0},
         '{make_request(cmte_pkg::OP_LOOKUP, 16'h1234, 8'hFF, 8'hFF, 16'hFFFF), 1'b0, '0},
         '{make_request(cmte_pkg::OP_LOOKUP, 16'h0101, 8'h00, 8'h00, 16'h0000), 1'b0, '0},
         '{make_request(cmte_pkg::OP_LOOKUP, 16'h0000, 8'h00, 8'h00, 16'h0000), 1'b0, '0},
         '{make_request(cmte_pkg::OP_LOOKUP, 16'h5A5A, 8'h00, 8'h00, 16'h0000), 1'b0, '0},
         '{make_request(cmte_pkg::OP_NONE, 16'h1234, cmte_pkg::EV_KEYBOARD, 8'h00, 16'h0000),
           1'b0, '0},
         '{make_request(cmte_pkg::OP_CLEAR, 16'hFFFF, 8'hFF, 8'hFF, 16'hFFFF), 1'b1, '0},
         '{make_request(cmte_pkg::OP_LOOKUP, 16'hFFFF, 8'h00, 8'h00, 16'h0000), 1'b1, '0},
         '{make_request(cmte_pkg::OP_LOAD, 16'h00FF, cmte_pkg::EV_MOUSE, cmte_pkg::MFN_MIDDLE,
                        16'hFFFF), 1'b1, pinned_rsp(1'b1, 0, 1, 0)}
      };

      @(negedge clock);
      while (reset) @(negedge clock);

      for (i = 0; i < $size(probe_table); i++)
         offer(probe_table[i].req, probe_table[i].pinned, probe_table[i].want);

      // skip counters: back to back system and unknown records
      steady = 1'b1;
      offer(make_request(cmte_pkg::OP_CLEAR, 16'h0000, 8'h00, 8'h00, 16'h0000));
      for (i = 0; i < SKIP_RECORDS; i++) begin
         offer(random_record((i % 2 == 0) ? cmte_pkg::EV_SYSTEM : pick_unknown_type(),
                             16'($urandom)));
      end
      offer(random_lookup());
      steady = 1'b0;

      // random part: one deep fill, then short episodes around a chord pool
      random_start = offered;
      fill_episode();
      while (offered - random_start < RANDOM_ITEMS) begin
         refresh_pool();
         if ($urandom_range(0, 2) != 0)
            offer(make_request(cmte_pkg::OP_CLEAR, 16'($urandom), 8'($urandom), 8'($urandom),
                               16'($urandom)));
         repeat ($urandom_range(20, 80)) offer(random_request());
      end

      @(negedge clock);
      req_ch.valid = 1'b0;
      while (pending_responses.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (mismatches == 0) begin
         $display("chord_mapping_table_engine verification clean");
      end else begin
         $display("chord_mapping_table_engine verification failed");
      end
      $finish;
   end

   // hang guard
   initial begin
      #50_000_000;
      $display("chord_mapping_table_engine verification failed");
      $finish;
   end

endmodule
